[design/vrc_pkg.sv]
// Package for the vertex rotation chain: payload structs, rotation codes,
// register indexes and the mode-to-rotation plan decoder.
// No dependencies; used by vrc_rot_stage and vertex_rotation_chain_core.
`default_nettype none

package vrc_pkg;

    // Input item: Q16.16 vertex and rotation mode
    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
        logic        [2:0]  mode;
    } in_item_t;

    // Result item: rotated Q16.16 vertex
    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
    } out_item_t;

    // Working vertex carried down the chain
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vertex_t;

    // Rotation applied by one slot of the chain
    typedef enum logic [1:0] {
        ROT_NONE,
        ROT_X,
        ROT_Y,
        ROT_Z
    } rot_op_t;

    // Rotations for the three slots, in order
    typedef struct packed {
        rot_op_t op0;
        rot_op_t op1;
        rot_op_t op2;
    } rot_plan_t;

    // Mode codes
    localparam logic [2:0] MODE_X   = 3'd0;
    localparam logic [2:0] MODE_Y   = 3'd1;
    localparam logic [2:0] MODE_Z   = 3'd2;
    localparam logic [2:0] MODE_XY  = 3'd3;
    localparam logic [2:0] MODE_XZ  = 3'd4;
    localparam logic [2:0] MODE_YZ  = 3'd5;
    localparam logic [2:0] MODE_YZX = 3'd6;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_HALF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_HALF = 2'd3;

    // Q2.30 reset values
    localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
    localparam logic signed [31:0] Q30_ZERO = 32'sd0;

    // Round-half-up offset for a Q30 product
    localparam logic signed [63:0] Q30_HALF = 64'sd536870912;

    // Decode a mode into the rotation of each slot
    function automatic rot_plan_t mode_plan(input logic [2:0] mode);
        rot_plan_t plan;
        plan = '{op0: ROT_NONE, op1: ROT_NONE, op2: ROT_NONE};
        unique case (mode)
            MODE_X:   plan.op0 = ROT_X;
            MODE_Y:   plan.op0 = ROT_Y;
            MODE_Z:   plan.op0 = ROT_Z;
            MODE_XY:  plan = '{op0: ROT_X, op1: ROT_Y, op2: ROT_NONE};
            MODE_XZ:  plan = '{op0: ROT_X, op1: ROT_Z, op2: ROT_NONE};
            MODE_YZ:  plan = '{op0: ROT_Y, op1: ROT_Z, op2: ROT_NONE};
            MODE_YZX: plan = '{op0: ROT_Y, op1: ROT_Z, op2: ROT_X};
            default:  plan = '{op0: ROT_NONE, op1: ROT_NONE, op2: ROT_NONE};
        endcase
        return plan;
    endfunction

endpackage

`default_nettype wire

[design/vrc_rot_stage.sv]
// One rotation slot of the chain: four 32x32 products, then round, sum
// and saturate. Two register stages. Depends on vrc_pkg.
`default_nettype none

module vrc_rot_stage
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire vrc_pkg::vertex_t   in_vert,
    input  wire vrc_pkg::rot_op_t   in_op,
    input  wire vrc_pkg::rot_plan_t in_plan,
    input  wire logic signed [31:0] cos_full,
    input  wire logic signed [31:0] sin_full,
    input  wire logic signed [31:0] cos_half,
    input  wire logic signed [31:0] sin_half,
    output logic                    out_valid,
    output vrc_pkg::vertex_t        out_vert,
    output vrc_pkg::rot_plan_t      out_plan
);

    // Round a Q30 product to Q16.16: add one half, floor by 2^30
    function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + vrc_pkg::Q30_HALF;
        return t[63:30];
    endfunction

    // Clamp a 35-bit sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Product stage registers
    logic                 mul_valid_reg;
    vrc_pkg::vertex_t     mul_vert_reg;
    vrc_pkg::rot_op_t     mul_op_reg;
    vrc_pkg::rot_plan_t   mul_plan_reg;
    logic signed [63:0]   p_ac_reg, p_bs_reg, p_as_reg, p_bc_reg;

    // Output stage registers
    logic                 out_valid_reg;
    vrc_pkg::vertex_t     out_vert_reg, out_vert_next;
    vrc_pkg::rot_plan_t   out_plan_reg;

    // Operand selection: a is the first rotated axis, b the second
    logic signed [31:0] op_a, op_b, op_c, op_s;
    always_comb
    begin
        unique case (in_op)
            vrc_pkg::ROT_X:
            begin
                op_a = in_vert.y;
                op_b = in_vert.z;
                op_c = cos_half;
                op_s = sin_half;
            end
            vrc_pkg::ROT_Y:
            begin
                op_a = in_vert.x;
                op_b = in_vert.z;
                op_c = cos_full;
                op_s = sin_full;
            end
            vrc_pkg::ROT_Z:
            begin
                op_a = in_vert.x;
                op_b = in_vert.y;
                op_c = cos_full;
                op_s = sin_full;
            end
            default:
            begin
                op_a = in_vert.x;
                op_b = in_vert.y;
                op_c = cos_full;
                op_s = sin_full;
            end
        endcase
    end

    // Hold the valid bit of each stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    // Register the four products with their vertex and plan
    always_ff @(posedge clk)
    begin
        mul_vert_reg <= in_vert;
        mul_op_reg   <= in_op;
        mul_plan_reg <= in_plan;
        p_ac_reg     <= op_a * op_c;
        p_bs_reg     <= op_b * op_s;
        p_as_reg     <= op_a * op_s;
        p_bc_reg     <= op_b * op_c;
    end

    // Round, combine and saturate, then write back the rotated axes
    logic signed [34:0] sum_u, sum_v;
    logic signed [31:0] new_u, new_v;
    always_comb
    begin
        sum_u = 35'(round_q30(p_ac_reg)) - 35'(round_q30(p_bs_reg));
        sum_v = 35'(round_q30(p_as_reg)) + 35'(round_q30(p_bc_reg));
        new_u = sat32(sum_u);
        new_v = sat32(sum_v);
        out_vert_next = mul_vert_reg;
        unique case (mul_op_reg)
            vrc_pkg::ROT_X:
            begin
                out_vert_next.y = new_u;
                out_vert_next.z = new_v;
            end
            vrc_pkg::ROT_Y:
            begin
                out_vert_next.x = new_u;
                out_vert_next.z = new_v;
            end
            vrc_pkg::ROT_Z:
            begin
                out_vert_next.x = new_u;
                out_vert_next.y = new_v;
            end
            default: out_vert_next = mul_vert_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_vert_reg <= out_vert_next;
        out_plan_reg <= mul_plan_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_vert  = out_vert_reg;
    assign out_plan  = out_plan_reg;

    // Every transfer into the slot leaves it through the product and output registers
    a_valid_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##2 out_valid)
        else $error("rotation slot lost a vertex");

    // An idle slot passes the vertex through untouched
    a_none_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_op == vrc_pkg::ROT_NONE) |-> ##2 (out_vert == $past(in_vert, 2)))
        else $error("idle rotation slot changed the vertex");

    // An X rotation keeps its x coordinate
    a_axis_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_op == vrc_pkg::ROT_X) |-> ##2 (out_vert.x == $past(in_vert.x, 2)))
        else $error("X rotation changed the x coordinate");

endmodule

`default_nettype wire

[design/vertex_rotation_chain_core.sv]
// Top level of the vertex rotation chain: register bank, input register
// and three rotation slots. Depends on vrc_pkg and vrc_rot_stage.
//
//  channel  handshake              payload                   direction
//  -------  ---------------------  ------------------------  ---------
//  command  start / busy           item   (vrc_pkg::in_item_t)   in
//  result   done (1-cycle strobe)  result (vrc_pkg::out_item_t)  out
//  config   cfg_valid / cfg_ready  cfg_index, cfg_data           in
//
// Throughput is one vertex per cycle; busy stays low.
// From the start transfer to the done strobe a vertex passes one input
// register, then three rotation slots of two stages each (multiply, then
// round/add/saturate). Reset clears the valid bits and loads cos registers
// with 1.0 and sin registers with 0. The receiver cannot stall, so the
// pipeline advances every cycle.
`default_nettype none

module vertex_rotation_chain_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire vrc_pkg::in_item_t             item,
    output logic                               done,
    output vrc_pkg::out_item_t                 result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic signed [31:0]            cfg_data
);

    // Configuration registers
    logic signed [31:0] cos_reg, sin_reg, cos_half_reg, sin_half_reg;

    // Input register
    logic               in_valid_reg;
    vrc_pkg::vertex_t   in_vert_reg;
    vrc_pkg::rot_plan_t in_plan_reg;

    // Slot outputs
    logic               s0_valid, s1_valid, s2_valid;
    vrc_pkg::vertex_t   s0_vert, s1_vert, s2_vert;
    vrc_pkg::rot_plan_t s0_plan, s1_plan, s2_plan;

    logic in_xfer;
    logic cfg_xfer;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_xfer   = start && !busy;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // Load a register on a config transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg      <= vrc_pkg::Q30_ONE;
            sin_reg      <= vrc_pkg::Q30_ZERO;
            cos_half_reg <= vrc_pkg::Q30_ONE;
            sin_half_reg <= vrc_pkg::Q30_ZERO;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                vrc_pkg::CFG_COS:      cos_reg      <= cfg_data;
                vrc_pkg::CFG_SIN:      sin_reg      <= cfg_data;
                vrc_pkg::CFG_COS_HALF: cos_half_reg <= cfg_data;
                vrc_pkg::CFG_SIN_HALF: sin_half_reg <= cfg_data;
                default:               cos_reg      <= cos_reg;
            endcase
        end
    end

    // Capture the vertex and decode its mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_xfer;
    end

    always_ff @(posedge clk)
    begin
        in_vert_reg.x <= item.x_in;
        in_vert_reg.y <= item.y_in;
        in_vert_reg.z <= item.z_in;
        in_plan_reg   <= vrc_pkg::mode_plan(item.mode);
    end

    // First, second and third rotation of the chain
    vrc_rot_stage u_slot0
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_vert   (in_vert_reg),
        .in_op     (in_plan_reg.op0),
        .in_plan   (in_plan_reg),
        .cos_full  (cos_reg),
        .sin_full  (sin_reg),
        .cos_half  (cos_half_reg),
        .sin_half  (sin_half_reg),
        .out_valid (s0_valid),
        .out_vert  (s0_vert),
        .out_plan  (s0_plan)
    );

    vrc_rot_stage u_slot1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid),
        .in_vert   (s0_vert),
        .in_op     (s0_plan.op1),
        .in_plan   (s0_plan),
        .cos_full  (cos_reg),
        .sin_full  (sin_reg),
        .cos_half  (cos_half_reg),
        .sin_half  (sin_half_reg),
        .out_valid (s1_valid),
        .out_vert  (s1_vert),
        .out_plan  (s1_plan)
    );

    vrc_rot_stage u_slot2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_vert   (s1_vert),
        .in_op     (s1_plan.op2),
        .in_plan   (s1_plan),
        .cos_full  (cos_reg),
        .sin_full  (sin_reg),
        .cos_half  (cos_half_reg),
        .sin_half  (sin_half_reg),
        .out_valid (s2_valid),
        .out_vert  (s2_vert),
        .out_plan  (s2_plan)
    );

    // Drive the result from the last slot's registers
    assign done         = s2_valid;
    assign result.x_out = s2_vert.x;
    assign result.y_out = s2_vert.y;
    assign result.z_out = s2_vert.z;

    // Every start transfer yields a done strobe after the input register and all three slots
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> ##7 done)
        else $error("vertex lost in the rotation chain");

    // No done strobe without a matching start transfer
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_xfer, 7))
        else $error("done strobe without a start transfer");

    // The third rotation of the plan reaches the last slot's output unchanged
    a_plan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid |-> (s2_plan.op2 == $past(in_plan_reg.op2, 6)))
        else $error("rotation plan corrupted along the chain");

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for vertex_rotation_chain_core: random and directed vertices under
// several angle settings, checked against an in-bench fixed-point rotation model.
// Depends on vrc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int PIPE_LATENCY = 7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q30_NEG_ONE = -32'sd1073741824;
    localparam logic [2:0] MODE_PASS = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    vrc_pkg::in_item_t item = '0;
    logic done;
    vrc_pkg::out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [vrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic signed [31:0] cfg_data = '0;

    // Angle registers as the block should hold them
    logic signed [31:0] cos_q30 = vrc_pkg::Q30_ONE;
    logic signed [31:0] sin_q30 = vrc_pkg::Q30_ZERO;
    logic signed [31:0] cos_half_q30 = vrc_pkg::Q30_ONE;
    logic signed [31:0] sin_half_q30 = vrc_pkg::Q30_ZERO;

    vrc_pkg::in_item_t pending_vertices[$];
    vrc_pkg::out_item_t expected_vertices[$];
    bit taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    vertex_rotation_chain_core DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Q16.16 times Q2.30, rounded half up back to Q16.16
    function automatic longint mul_round(input longint a, input longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return COORD_MAX;
        if (v < -64'sd2147483648)
            return COORD_MIN;
        return v[31:0];
    endfunction

    // Rotate one coordinate pair (a, b) by the cosine/sine pair (c, s)
    function automatic void turn_pair(inout logic signed [31:0] a,
                                      inout logic signed [31:0] b,
                                      input logic signed [31:0] c,
                                      input logic signed [31:0] s);
        longint la;
        longint lb;
        la = a;
        lb = b;
        a = clamp32(mul_round(la, c) - mul_round(lb, s));
        b = clamp32(mul_round(la, s) + mul_round(lb, c));
    endfunction

    function automatic vrc_pkg::vertex_t rotate_axis(input vrc_pkg::vertex_t v,
                                                     input vrc_pkg::rot_op_t op);
        vrc_pkg::vertex_t w;
        w = v;
        case (op)
            vrc_pkg::ROT_X: turn_pair(w.y, w.z, cos_half_q30, sin_half_q30);
            vrc_pkg::ROT_Y: turn_pair(w.x, w.z, cos_q30, sin_q30);
            vrc_pkg::ROT_Z: turn_pair(w.x, w.y, cos_q30, sin_q30);
            default: ;
        endcase
        return w;
    endfunction

    function automatic vrc_pkg::out_item_t rotate_vertex(input vrc_pkg::in_item_t v);
        vrc_pkg::vertex_t w;
        vrc_pkg::out_item_t r;
        w.x = v.x_in;
        w.y = v.y_in;
        w.z = v.z_in;
        case (v.mode)
            vrc_pkg::MODE_X:
                w = rotate_axis(w, vrc_pkg::ROT_X);
            vrc_pkg::MODE_Y:
                w = rotate_axis(w, vrc_pkg::ROT_Y);
            vrc_pkg::MODE_Z:
                w = rotate_axis(w, vrc_pkg::ROT_Z);
            vrc_pkg::MODE_XY:
                w = rotate_axis(rotate_axis(w, vrc_pkg::ROT_X), vrc_pkg::ROT_Y);
            vrc_pkg::MODE_XZ:
                w = rotate_axis(rotate_axis(w, vrc_pkg::ROT_X), vrc_pkg::ROT_Z);
            vrc_pkg::MODE_YZ:
                w = rotate_axis(rotate_axis(w, vrc_pkg::ROT_Y), vrc_pkg::ROT_Z);
            vrc_pkg::MODE_YZX:
            begin
                w = rotate_axis(rotate_axis(w, vrc_pkg::ROT_Y), vrc_pkg::ROT_Z);
                w = rotate_axis(w, vrc_pkg::ROT_X);
            end
            default: ;
        endcase
        r.x_out = w.x;
        r.y_out = w.y;
        r.z_out = w.z;
        return r;
    endfunction

    // Drive commands in bursts; hold the current one until it is transferred
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !taken)
        begin
            // hold
        end
        else
        begin
            taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_vertices.size() > 0)
            begin
                item <= pending_vertices.pop_front();
                start <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left = burst_left - 1;
                end
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Record command transfers and check results
    always @(posedge clk)
    begin
        vrc_pkg::out_item_t want;
        if (rst_n && start && !busy)
        begin
            taken = 1'b1;
            expected_vertices = {expected_vertices, rotate_vertex(item)};
        end
        if (rst_n && done)
        begin
            if (expected_vertices.size() == 0)
            begin
                $display("%0t unexpected result: expected none, got %0d %0d %0d", $time,
                         result.x_out, result.y_out, result.z_out);
                mismatch_count++;
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (result.x_out !== want.x_out)
                begin
                    $display("%0t x_out mismatch: expected %0d, got %0d", $time,
                             want.x_out, result.x_out);
                    mismatch_count++;
                end
                if (result.y_out !== want.y_out)
                begin
                    $display("%0t y_out mismatch: expected %0d, got %0d", $time,
                             want.y_out, result.y_out);
                    mismatch_count++;
                end
                if (result.z_out !== want.z_out)
                begin
                    $display("%0t z_out mismatch: expected %0d, got %0d", $time,
                             want.z_out, result.z_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time,
                     expected_vertices.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input logic [2:0] mode);
        vrc_pkg::in_item_t v;
        v.x_in = x;
        v.y_in = y;
        v.z_in = z;
        v.mode = mode;
        pending_vertices = {pending_vertices, v};
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3, 4: return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] q30_of(input real r);
        return $rtoi(r * 1073741824.0);
    endfunction

    // Wait until every command is transferred and every result has come back
    task automatic drain();
        while (pending_vertices.size() != 0 || start || expected_vertices.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vrc_pkg::CFG_IDX_W-1:0] idx,
                             input logic signed [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            vrc_pkg::CFG_COS: cos_q30 = val;
            vrc_pkg::CFG_SIN: sin_q30 = val;
            vrc_pkg::CFG_COS_HALF: cos_half_q30 = val;
            vrc_pkg::CFG_SIN_HALF: sin_half_q30 = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_angles(input logic signed [31:0] c, input logic signed [31:0] s,
                              input logic signed [31:0] ch, input logic signed [31:0] sh);
        drain();
        write_reg(vrc_pkg::CFG_COS, c);
        write_reg(vrc_pkg::CFG_SIN, s);
        write_reg(vrc_pkg::CFG_COS_HALF, ch);
        write_reg(vrc_pkg::CFG_SIN_HALF, sh);
    endtask

    task automatic set_random_angle();
        real theta;
        theta = $urandom_range(0, 359999) / 1000.0 * 3.14159265358979 / 180.0;
        set_angles(q30_of($cos(theta)), q30_of($sin(theta)),
                   q30_of($cos(theta / 2.0)), q30_of($sin(theta / 2.0)));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset angles: every mode, including the unused one, mostly on extreme coordinates
        add_vertex(COORD_MAX, COORD_MIN, 32'sh0001_8000, vrc_pkg::MODE_X);
        add_vertex(COORD_MIN, COORD_MAX, -32'sh0001_8000, vrc_pkg::MODE_Y);
        add_vertex(COORD_MAX, COORD_MAX, COORD_MIN, vrc_pkg::MODE_Z);
        add_vertex(COORD_MIN, COORD_MIN, COORD_MAX, vrc_pkg::MODE_XY);
        add_vertex(32'sd1, -32'sd1, COORD_MAX, vrc_pkg::MODE_XZ);
        add_vertex(32'sd0, COORD_MAX, COORD_MIN, vrc_pkg::MODE_YZ);
        add_vertex(COORD_MAX, 32'sd0, COORD_MIN, vrc_pkg::MODE_YZX);
        add_vertex(COORD_MIN, 32'sh0001_0000, COORD_MAX, MODE_PASS);

        // Skewed angles: rounding on small values and saturation on large ones
        set_angles(32'sd536870912, 32'sd929887697, 32'sd929887697, 32'sd536870912);
        add_vertex(32'sd1, -32'sd1, 32'sd3, vrc_pkg::MODE_X);
        add_vertex(32'sd1, -32'sd1, 32'sd3, vrc_pkg::MODE_Y);
        add_vertex(32'sd1, -32'sd1, 32'sd3, vrc_pkg::MODE_Z);
        add_vertex(32'sd1, -32'sd1, 32'sd3, vrc_pkg::MODE_XY);
        add_vertex(32'sd1, -32'sd1, 32'sd3, vrc_pkg::MODE_XZ);
        add_vertex(32'sd1, -32'sd1, 32'sd3, vrc_pkg::MODE_YZ);
        add_vertex(32'sd1, -32'sd1, 32'sd3, vrc_pkg::MODE_YZX);
        add_vertex(32'sd1, -32'sd1, 32'sd3, MODE_PASS);
        add_vertex(COORD_MAX, COORD_MAX, COORD_MAX, vrc_pkg::MODE_YZX);
        add_vertex(COORD_MIN, COORD_MIN, COORD_MIN, vrc_pkg::MODE_YZX);
        add_vertex(COORD_MIN, COORD_MAX, COORD_MIN, vrc_pkg::MODE_XY);
        add_vertex(COORD_MAX, COORD_MIN, COORD_MAX, vrc_pkg::MODE_XZ);
        add_vertex(32'sd0, 32'sd0, 32'sd0, vrc_pkg::MODE_YZ);
        add_vertex(-32'sd1, -32'sd1, -32'sd1, vrc_pkg::MODE_Y);
        add_vertex(32'sd2, -32'sd3, 32'sd1, vrc_pkg::MODE_Z);

        // Random vertices under a sweep of angle settings, extremes included
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                1: set_angles(vrc_pkg::Q30_ONE, vrc_pkg::Q30_ONE,
                              vrc_pkg::Q30_ONE, vrc_pkg::Q30_ONE);
                2: set_angles(Q30_NEG_ONE, Q30_NEG_ONE, Q30_NEG_ONE, Q30_NEG_ONE);
                3: set_angles(vrc_pkg::Q30_ZERO, vrc_pkg::Q30_ONE,
                              vrc_pkg::Q30_ZERO, Q30_NEG_ONE);
                4: set_angles($urandom, $urandom, $urandom, $urandom);
                5: set_angles(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
                default: set_random_angle();
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                add_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 7));
        end

        drain();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[vertex_rotation_chain_core.f]
design/vrc_pkg.sv
design/vrc_rot_stage.sv
design/vertex_rotation_chain_core.sv
test/tb.sv
